// ===== src/mdct_pkg.sv =====
// Shared constants, types and helpers of the minimum-delay coverage table.
package mdct_pkg;

  localparam int MAX_NODES    = 256;
  localparam int MAX_MESSAGES = 256;
  localparam int TBL_DEPTH    = MAX_NODES * MAX_MESSAGES;
  localparam int TBL_AW       = $clog2(TBL_DEPTH);
  localparam int PAIR_W       = TBL_AW + 1;
  localparam int SUM_W        = TBL_AW + 8;
  localparam int CNT_W        = 9;
  localparam int DIV_NW       = 31;
  localparam int DIV_DW       = PAIR_W;
  localparam int DIV_CW       = $clog2(DIV_NW + 1);
  localparam int COV_SCALE    = 10000;
  localparam int MEAN_SCALE   = 100;

  localparam logic [7:0] UNREACHED = 8'hFF;

  localparam logic REG_NODE_COUNT    = 1'b0;
  localparam logic REG_MESSAGE_COUNT = 1'b1;

  typedef enum logic {
    OP_RECORD  = 1'b0,
    OP_SUMMARY = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_DELAY = 2'd1,
    ST_RANGE = 2'd2,
    ST_NONE  = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_REC,
    S_WALK,
    S_SCALE,
    S_COV_GO,
    S_COV_WAIT,
    S_MEAN_GO,
    S_MEAN_WAIT,
    S_DONE
  } fsm_e;

  typedef struct packed {
    logic              re;
    logic [TBL_AW-1:0] raddr;
    logic              we;
    logic [TBL_AW-1:0] waddr;
    logic [7:0]        wdata;
  } mem_req_t;

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] num;
    logic [DIV_DW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_NW-1:0] quo;
  } div_rsp_t;

  function automatic logic [CNT_W-1:0] clamp_cnt(logic [CNT_W-1:0] v, logic [CNT_W-1:0] hi);
    logic [CNT_W-1:0] r;
    if (v == '0) begin
      r = CNT_W'(1);
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// ===== src/mdct_mem.sv =====
// Delay table: one write port, one read port with registered read data.
module mdct_mem import mdct_pkg::*; (
  input  logic     clk_i,
  input  mem_req_t req_i,
  output logic [7:0] rdata_o
);

  logic [7:0] mem_q [TBL_DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/mdct_div.sv =====
// Restoring divider, one quotient bit per cycle.
module mdct_div import mdct_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic              run_q, run_d;
  logic [DIV_CW-1:0] cnt_q, cnt_d;
  logic [DIV_NW-1:0] num_q;
  logic [DIV_DW-1:0] rem_q;
  logic [DIV_DW-1:0] den_q;
  logic [DIV_DW:0]   rem_sh;
  logic [DIV_DW:0]   diff;
  logic              ge;
  logic              step;

  assign step   = run_q && (cnt_q != '0);
  assign rem_sh = {rem_q, num_q[DIV_NW-1]};
  assign diff   = rem_sh - {1'b0, den_q};
  assign ge     = rem_sh >= {1'b0, den_q};

  always_comb begin
    run_d = run_q;
    cnt_d = cnt_q;
    if (req_i.start) begin
      run_d = 1'b1;
      cnt_d = DIV_CW'(DIV_NW);
    end else if (step) begin
      cnt_d = cnt_q - DIV_CW'(1);
    end else if (run_q) begin
      run_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      run_q <= run_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      num_q <= req_i.num;
      den_q <= req_i.den;
      rem_q <= '0;
    end else if (step) begin
      num_q <= {num_q[DIV_NW-2:0], ge};
      rem_q <= ge ? diff[DIV_DW-1:0] : rem_sh[DIV_DW-1:0];
    end
  end

  assign rsp_o.done = run_q && (cnt_q == '0);
  assign rsp_o.quo  = num_q;

endmodule

// ===== src/min_delay_coverage_table.sv =====
// Minimum-delay coverage table: control, configuration and stream ports.
//
// Items enter on the s_ group; s_tuser_i selects record (0) or summary (1).
// A record folds hop_delay into the table entry of (message, node) keeping
// the minimum; a summary walks all pairs in use and reports coverage, mean
// delay, reached count and delay sum. Every item gives exactly one result
// on the m_ group, with the status code on m_tuser_o.
// One item is worked at a time. A record reads its table entry on the accept,
// then in S_REC writes back the smaller delay (one table read, one write
// back) and registers its result once the output register is free.
// A summary reads node_count*message_count entries, one per cycle on the
// single read port; its result follows the walk drain, S_SCALE and two divisions,
// or S_SCALE alone when nothing was reached and the divisions are skipped.
// After reset the table is swept to "unreached", one entry per cycle, over all
// 65536 entries; s_tready_o stays low meanwhile, configuration writes are
// taken. A result waits in the output register while m_tready_i is low;
// the next item may be taken meanwhile but its result waits behind it.
// Registers: node_count at 0x0, message_count at 0x4 (APB, no wait states).
module min_delay_coverage_table import mdct_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [31:0] s_tdata_i,   // message_index[7:0], node_index[15:8], hop_delay[25:16]
  input  logic        s_tuser_i,   // operation[0]
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [71:0] m_tdata_o,   // coverage_hundredths[13:0], mean_delay_hundredths[28:14],
                                   // hit_count[45:29], delay_total[69:46]
  output logic [1:0]  m_tuser_o,   // status[1:0]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  fsm_e state_q, state_d;

  logic [CNT_W-1:0]  node_cnt_q, msg_cnt_q;
  logic [CNT_W-1:0]  nc_w, mc_w;
  logic [TBL_AW-1:0] clr_q;
  logic [PAIR_W-1:0] k_q, tot_q;
  logic              rdv_q;
  logic [PAIR_W-1:0] reached_q;
  logic [SUM_W-1:0]  sum_q;
  logic [TBL_AW-1:0] addr_q;
  logic [7:0]        d_q;

  logic [1:0]        res_status_q;
  logic [13:0]       res_cov_q;
  logic [14:0]       res_mean_q;
  logic [16:0]       res_reached_q;
  logic [23:0]       res_total_q;

  logic              m_tvalid_q;
  logic [71:0]       m_tdata_q;
  logic [1:0]        m_tuser_q;

  logic [7:0]        in_msg, in_node;
  logic [9:0]        in_delay;
  logic              in_fire, out_free, emit, walk_more;
  status_e           chk_status;
  logic [PAIR_W-1:0] idx_w;
  logic [2*CNT_W-1:0] tot_w;
  logic [7:0]        rdata;
  logic              cfg_wr;

  mem_req_t mem_req;
  div_req_t div_req;
  div_rsp_t div_rsp;

  mdct_mem u_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (rdata)
  );

  mdct_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // configuration
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_MESSAGE_COUNT) ? {23'd0, msg_cnt_q} : {23'd0, node_cnt_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_cnt_q <= CNT_W'(MAX_NODES);
      msg_cnt_q  <= CNT_W'(MAX_MESSAGES);
    end else if (cfg_wr) begin
      if (paddr[2] == REG_NODE_COUNT) begin
        node_cnt_q <= pwdata[CNT_W-1:0];
      end else begin
        msg_cnt_q <= pwdata[CNT_W-1:0];
      end
    end
  end

  assign nc_w = clamp_cnt(node_cnt_q, CNT_W'(MAX_NODES));
  assign mc_w = clamp_cnt(msg_cnt_q, CNT_W'(MAX_MESSAGES));

  // input decode
  assign in_msg   = s_tdata_i[7:0];
  assign in_node  = s_tdata_i[15:8];
  assign in_delay = s_tdata_i[25:16];
  assign in_fire  = s_tvalid_i && s_tready_o;

  always_comb begin
    if ((CNT_W'(in_msg) >= mc_w) || (CNT_W'(in_node) >= nc_w)) begin
      chk_status = ST_RANGE;
    end else if (in_delay >= 10'(UNREACHED)) begin
      chk_status = ST_DELAY;
    end else begin
      chk_status = ST_OK;
    end
  end

  assign idx_w     = PAIR_W'(in_msg) * PAIR_W'(nc_w) + PAIR_W'(in_node);
  assign tot_w     = (2*CNT_W)'(nc_w) * (2*CNT_W)'(mc_w);
  assign walk_more = k_q < tot_q;
  assign out_free  = !m_tvalid_q || m_tready_i;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (clr_q == '1) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_fire) begin
          if (op_e'(s_tuser_i) == OP_SUMMARY) begin
            state_d = S_WALK;
          end else if (chk_status == ST_OK) begin
            state_d = S_REC;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_REC: begin
        state_d = out_free ? S_IDLE : S_DONE;
      end
      S_WALK: begin
        if (!walk_more && !rdv_q) state_d = S_SCALE;
      end
      S_SCALE: begin
        state_d = (reached_q == '0) ? S_DONE : S_COV_GO;
      end
      S_COV_GO: begin
        state_d = S_COV_WAIT;
      end
      S_COV_WAIT: begin
        if (div_rsp.done) state_d = S_MEAN_GO;
      end
      S_MEAN_GO: begin
        state_d = S_MEAN_WAIT;
      end
      S_MEAN_WAIT: begin
        if (div_rsp.done) state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control outputs
  always_comb begin
    s_tready_o    = 1'b0;
    emit          = 1'b0;
    mem_req.re    = 1'b0;
    mem_req.raddr = idx_w[TBL_AW-1:0];
    mem_req.we    = 1'b0;
    mem_req.waddr = addr_q;
    mem_req.wdata = d_q;
    div_req.start = 1'b0;
    div_req.num   = DIV_NW'(reached_q) * DIV_NW'(COV_SCALE);
    div_req.den   = tot_q;
    case (state_q)
      S_CLEAR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = clr_q;
        mem_req.wdata = UNREACHED;
      end
      S_IDLE: begin
        s_tready_o = 1'b1;
        mem_req.re = s_tvalid_i && (op_e'(s_tuser_i) == OP_RECORD);
      end
      S_REC: begin
        mem_req.we = d_q < rdata;
        emit       = out_free;
      end
      S_WALK: begin
        mem_req.re    = walk_more;
        mem_req.raddr = k_q[TBL_AW-1:0];
      end
      S_COV_GO: begin
        div_req.start = 1'b1;
      end
      S_MEAN_GO: begin
        div_req.start = 1'b1;
        div_req.num   = DIV_NW'(sum_q) * DIV_NW'(MEAN_SCALE);
        div_req.den   = reached_q;
      end
      S_DONE: begin
        emit = out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      clr_q      <= '0;
      rdv_q      <= 1'b0;
      m_tvalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLEAR) clr_q <= clr_q + TBL_AW'(1);
      rdv_q <= (state_q == S_WALK) && walk_more;
      if (emit) begin
        m_tvalid_q <= 1'b1;
      end else if (m_tready_i) begin
        m_tvalid_q <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      addr_q        <= idx_w[TBL_AW-1:0];
      d_q           <= in_delay[7:0];
      tot_q         <= tot_w[PAIR_W-1:0];
      k_q           <= '0;
      reached_q     <= '0;
      sum_q         <= '0;
      res_status_q  <= (op_e'(s_tuser_i) == OP_SUMMARY) ? ST_OK : chk_status;
      res_cov_q     <= '0;
      res_mean_q    <= '0;
      res_reached_q <= '0;
      res_total_q   <= '0;
    end
    if ((state_q == S_WALK) && walk_more) k_q <= k_q + PAIR_W'(1);
    if ((state_q == S_WALK) && rdv_q && (rdata != UNREACHED)) begin
      reached_q <= reached_q + PAIR_W'(1);
      sum_q     <= sum_q + SUM_W'(rdata);
    end
    if (state_q == S_SCALE) begin
      if (reached_q == '0) begin
        res_status_q <= ST_NONE;
      end else begin
        res_reached_q <= reached_q;
        res_total_q   <= sum_q;
      end
    end
    if ((state_q == S_COV_WAIT) && div_rsp.done) res_cov_q <= div_rsp.quo[13:0];
    if ((state_q == S_MEAN_WAIT) && div_rsp.done) res_mean_q <= div_rsp.quo[14:0];
    if (emit) begin
      m_tuser_q <= res_status_q;
      m_tdata_q <= {2'b00, res_total_q, res_reached_q, res_mean_q, res_cov_q};
    end
  end

  assign m_tvalid_o = m_tvalid_q;
  assign m_tdata_o  = m_tdata_q;
  assign m_tuser_o  = m_tuser_q;

endmodule
